// ===== src/mgws_pkg.sv =====
package mgws_pkg;

  localparam int CFG_W   = 11;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;
  localparam int GAP_W   = 43;

  localparam int REG_WINDOW_LEN = 0;

  typedef struct packed {
    logic valid;
    logic start;
    logic pair;
  } tag_t;

endpackage

// ===== src/mgws_if.sv =====
interface mgws_sample_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_new;

  modport source (output valid, sample, start_new, input ready);
  modport sink   (input valid, sample, start_new, output ready);
endinterface

interface mgws_result_if ();
  logic                         valid;
  logic                         ready;
  logic [mgws_pkg::GAP_W-1:0]   best_gap;
  logic                         gap_valid;

  modport source (output valid, best_gap, gap_valid, input ready);
  modport sink   (input valid, best_gap, gap_valid, output ready);
endinterface

// ===== src/mgws_ram.sv =====
module mgws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mgws_cfg.sv =====
module mgws_cfg #(
  parameter int MAX_WINDOW = 1024,
  localparam int KW        = $clog2(MAX_WINDOW + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mgws_pkg::APB_AW-1:0]   paddr,
  input  logic [mgws_pkg::APB_DW-1:0]   pwdata,
  output logic [mgws_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [KW-1:0]                 k_eff
);

  logic [mgws_pkg::CFG_W-1:0] window_len;
  logic [mgws_pkg::CFG_W-1:0] wr_val;
  logic                       sel_len;
  logic                       wr;
  logic [KW-1:0]              k_next;

  assign sel_len = (paddr[mgws_pkg::APB_AW-1] == 1'(mgws_pkg::REG_WINDOW_LEN));
  assign wr      = psel && penable && pwrite && pready && sel_len;
  assign wr_val  = pwdata[mgws_pkg::CFG_W-1:0];
  assign pready  = 1'b1;

  // zero means one, anything above the delay depth saturates
  always_comb begin
    if (wr_val == '0) begin
      k_next = KW'(1);
    end else if (32'(wr_val) > 32'(MAX_WINDOW)) begin
      k_next = KW'(MAX_WINDOW);
    end else begin
      k_next = KW'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= mgws_pkg::CFG_W'(1);
      k_eff      <= KW'(1);
    end else if (wr) begin
      window_len <= wr_val;
      k_eff      <= k_next;
    end
  end

  assign prdata = sel_len ? mgws_pkg::APB_DW'(window_len) : '0;

endmodule

// ===== src/mgws_window.sv =====
module mgws_window #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32,
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int KW    = $clog2(MAX_WINDOW + 1),
  localparam int CW    = $clog2(2 * MAX_WINDOW + 1),
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [KW-1:0]                 k_eff,
  input  logic                          adv,
  input  logic                          acc,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start,
  output mgws_pkg::tag_t                s2_tag,
  output logic signed [SUM_W-1:0]       s2_sum,
  output logic signed [SUM_W-1:0]       s2_lmax,
  output logic signed [SUM_W-1:0]       s2_lmin
);

  localparam logic signed [SUM_W-1:0] SUM_NEG = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_POS = {1'b0, {(SUM_W-1){1'b1}}};

  // issue side
  logic [AW-1:0] wp;
  logic [AW-1:0] base;
  logic [AW-1:0] rd;
  logic [31:0]   rd_full;

  // stage 1
  logic                          s1_v;
  logic                          s1_start;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [AW-1:0]                 s1_waddr;
  logic [SAMPLE_BITS-1:0]        ram_s;
  logic [SUM_W-1:0]              ram_w;

  // sequence state
  logic signed [SUM_W-1:0]       window_sum;
  logic [CW-1:0]                 seen;
  logic signed [SUM_W-1:0]       lmax;
  logic signed [SUM_W-1:0]       lmin;
  logic signed [SAMPLE_BITS-1:0] last_x;

  logic signed [SUM_W-1:0]       cur_sum;
  logic [CW-1:0]                 cur_seen;
  logic signed [SUM_W-1:0]       cur_lmax;
  logic signed [SUM_W-1:0]       cur_lmin;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic signed [SUM_W-1:0]       old_w;
  logic signed [SUM_W-1:0]       x_ext;
  logic signed [SUM_W-1:0]       sub_ext;
  logic [CW-1:0]                 t;
  logic                          use_s;
  logic                          pair;
  logic signed [SUM_W-1:0]       sum_next;
  logic signed [SUM_W-1:0]       lmax_next;
  logic signed [SUM_W-1:0]       lmin_next;
  logic                          wr_en;

  assign base    = in_start ? '0 : wp;
  assign rd_full = 32'(base) + 32'(MAX_WINDOW) - 32'(k_eff);
  assign rd      = (rd_full >= 32'(MAX_WINDOW)) ? AW'(rd_full - 32'(MAX_WINDOW))
                                                : AW'(rd_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (acc) begin
      wp <= (32'(base) == 32'(MAX_WINDOW - 1)) ? '0 : AW'(32'(base) + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_start <= in_start;
      s1_x     <= in_sample;
      s1_waddr <= base;
    end
  end

  assign wr_en = adv && s1_v;

  mgws_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_sample_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_waddr),
    .wdata (s1_x),
    .re    (acc),
    .raddr (rd),
    .rdata (ram_s)
  );

  mgws_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WINDOW)) u_window_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_waddr),
    .wdata (sum_next),
    .re    (acc),
    .raddr (rd),
    .rdata (ram_w)
  );

  always_comb begin
    cur_sum  = s1_start ? '0 : window_sum;
    cur_seen = s1_start ? '0 : seen;
    cur_lmax = s1_start ? SUM_NEG : lmax;
    cur_lmin = s1_start ? SUM_POS : lmin;

    // window of one: the entry is the one the previous beat writes now
    if (k_eff == KW'(1)) begin
      old_s = last_x;
      old_w = window_sum;
    end else begin
      old_s = $signed(ram_s);
      old_w = $signed(ram_w);
    end

    t     = (32'(cur_seen) >= 32'(2 * MAX_WINDOW)) ? cur_seen : CW'(32'(cur_seen) + 32'd1);
    use_s = (32'(cur_seen) >= 32'(k_eff));
    pair  = (32'(t) >= (32'(k_eff) << 1));

    x_ext    = SUM_W'(s1_x);
    sub_ext  = use_s ? SUM_W'(old_s) : '0;
    sum_next = cur_sum + x_ext - sub_ext;

    lmax_next = (pair && (old_w > cur_lmax)) ? old_w : cur_lmax;
    lmin_next = (pair && (old_w < cur_lmin)) ? old_w : cur_lmin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      seen       <= '0;
      lmax       <= SUM_NEG;
      lmin       <= SUM_POS;
    end else if (wr_en) begin
      window_sum <= sum_next;
      seen       <= t;
      lmax       <= lmax_next;
      lmin       <= lmin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_x <= s1_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else if (adv) begin
      s2_tag.valid <= s1_v;
      s2_tag.start <= s1_start;
      s2_tag.pair  <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      s2_sum  <= sum_next;
      s2_lmax <= lmax_next;
      s2_lmin <= lmin_next;
    end
  end

endmodule

// ===== src/mgws_gap.sv =====
module mgws_gap #(
  parameter int SUM_W = 42,
  localparam int DW   = SUM_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  mgws_pkg::tag_t              s2_tag,
  input  logic signed [SUM_W-1:0]     s2_sum,
  input  logic signed [SUM_W-1:0]     s2_lmax,
  input  logic signed [SUM_W-1:0]     s2_lmin,
  output logic                        out_valid,
  output logic [mgws_pkg::GAP_W-1:0]  best_gap,
  output logic                        gap_valid
);

  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;
  logic signed [DW-1:0] gap_now;

  mgws_pkg::tag_t       s3_tag;
  logic [DW-1:0]        s3_gap;

  logic [DW-1:0]        best;
  logic                 found;
  logic [DW-1:0]        base_best;
  logic                 base_found;

  // left max >= left min, so the larger one-sided gap is the absolute one
  always_comb begin
    d1      = DW'(s2_sum) - DW'(s2_lmin);
    d2      = DW'(s2_lmax) - DW'(s2_sum);
    gap_now = (d1 > d2) ? d1 : d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else if (adv) begin
      s3_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_tag.valid) begin
      s3_gap <= gap_now;
    end
  end

  assign base_best  = s3_tag.start ? '0 : best;
  assign base_found = s3_tag.start ? 1'b0 : found;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      best      <= '0;
      found     <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_tag.valid;
      if (s3_tag.valid) begin
        if (s3_tag.pair && (!base_found || (s3_gap > base_best))) begin
          best <= s3_gap;
        end else begin
          best <= base_best;
        end
        found <= base_found || s3_tag.pair;
      end
    end
  end

  assign best_gap  = found ? mgws_pkg::GAP_W'(best) : '0;
  assign gap_valid = found;

endmodule

// ===== src/max_gap_between_window_sums.sv =====
// Streaming largest gap between two non-overlapping sliding-window sums.
// One sample beat is taken per clock unless stalled; each passes stages 1 to 3
// and the result register, in order, one result per sample. The rate is set by
// the single read and single write per cycle on the two delay-line RAMs (past
// samples and past window sums, MAX_WINDOW entries each), read at write pointer
// minus window_len and written back from stage 1; a window of one is served by
// forwarding from registers. When the result register is full and not taken,
// the whole pipe holds and ready drops. The delay lines need no clearing after
// reset or start_new: entries are only used once written in the current
// sequence. Write window_len (register 0) only while idle; the block does not
// enforce it. 0 acts as 1, values above MAX_WINDOW saturate.
module max_gap_between_window_sums #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mgws_pkg::APB_AW-1:0]   paddr,
  input  logic [mgws_pkg::APB_DW-1:0]   pwdata,
  output logic [mgws_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  mgws_sample_if.sink                   samples,
  mgws_result_if.source                 gaps
);

  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

  logic [KW-1:0]           k_eff;
  logic                    adv;
  logic                    acc;
  mgws_pkg::tag_t          s2_tag;
  logic signed [SUM_W-1:0] s2_sum;
  logic signed [SUM_W-1:0] s2_lmax;
  logic signed [SUM_W-1:0] s2_lmin;

  assign adv           = !gaps.valid || gaps.ready;
  assign samples.ready = adv;
  assign acc           = samples.valid && adv;

  mgws_cfg #(.MAX_WINDOW(MAX_WINDOW)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .k_eff   (k_eff)
  );

  mgws_window #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_window (
    .clk       (clk),
    .rst       (rst),
    .k_eff     (k_eff),
    .adv       (adv),
    .acc       (acc),
    .in_sample (samples.sample),
    .in_start  (samples.start_new),
    .s2_tag    (s2_tag),
    .s2_sum    (s2_sum),
    .s2_lmax   (s2_lmax),
    .s2_lmin   (s2_lmin)
  );

  mgws_gap #(.SUM_W(SUM_W)) u_gap (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s2_tag    (s2_tag),
    .s2_sum    (s2_sum),
    .s2_lmax   (s2_lmax),
    .s2_lmin   (s2_lmin),
    .out_valid (gaps.valid),
    .best_gap  (gaps.best_gap),
    .gap_valid (gaps.gap_valid)
  );

endmodule

// ===== bench/tb_max_gap_between_window_sums.sv =====
`timescale 1ns / 1ps

module tb_max_gap_between_window_sums;
  import mgws_pkg::*;

  localparam int MAXW = 1024;
  localparam longint SUM_HI = (longint'(1) << 41) - 1;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [GAP_W-1:0] best_gap;
    logic             gap_valid;
  } gap_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        restart;
  } smp_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mgws_sample_if #(.SAMPLE_BITS(32)) smp_if ();
  mgws_result_if                     res_if ();

  max_gap_between_window_sums #(
    .MAX_WINDOW (MAXW),
    .SAMPLE_BITS(32)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .samples(smp_if),
    .gaps   (res_if)
  );

  always #5 clk = ~clk;

  // window-sum model state
  longint           smp_hist [MAXW];
  longint           win_hist [MAXW];
  int unsigned      wr_ptr;
  int unsigned      seen;
  longint           run_sum;
  longint           left_hi;
  longint           left_lo;
  logic [63:0]      best_abs;
  bit               have_pair;
  logic [CFG_W-1:0] win_cfg;

  smp_beat_t pending_beats[$];
  gap_res_t  gap_expected[$];

  int  beats_queued;
  int  samples_taken;
  int  results_seen;
  int  pair_results;
  int  settings_run;
  int  errors;
  bit  beat_in;
  logic [GAP_W-1:0] widest_gap = '0;

  function automatic void clear_seq();
    foreach (smp_hist[i]) begin
      smp_hist[i] = 0;
      win_hist[i] = 0;
    end
    wr_ptr    = 0;
    run_sum   = 0;
    seen      = 0;
    left_hi   = -SUM_HI - 1;
    left_lo   = SUM_HI;
    best_abs  = '0;
    have_pair = 1'b0;
  endfunction

  function automatic logic [63:0] span(longint a, longint b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic gap_res_t predict_gap(logic [31:0] raw, logic restart);
    int unsigned k;
    int unsigned rd;
    int unsigned t;
    longint      x;
    longint      old_s;
    longint      old_w;
    logic [63:0] g1;
    logic [63:0] g2;
    gap_res_t    r;
    k = win_cfg;
    if (k == 0) k = 1;
    if (k > MAXW) k = MAXW;
    if (restart) clear_seq();
    x = longint'($signed(raw));
    rd = (wr_ptr + MAXW - k) % MAXW;
    old_s = smp_hist[rd];
    old_w = win_hist[rd];
    t = seen + 1;
    if (t > 2 * MAXW) t = 2 * MAXW;
    run_sum = run_sum + x;
    if (seen >= k) run_sum = run_sum - old_s;
    smp_hist[wr_ptr] = x;
    win_hist[wr_ptr] = run_sum;
    wr_ptr = (wr_ptr + 1) % MAXW;
    if (t >= 2 * k) begin
      if (old_w > left_hi) left_hi = old_w;
      if (old_w < left_lo) left_lo = old_w;
      g1 = span(run_sum, left_lo);
      g2 = span(left_hi, run_sum);
      if (g2 > g1) g1 = g2;
      if (!have_pair || g1 > best_abs) best_abs = g1;
      have_pair = 1'b1;
    end
    seen = t;
    r.best_gap  = have_pair ? best_abs[GAP_W-1:0] : '0;
    r.gap_valid = have_pair;
    return r;
  endfunction

  // sample driver: bursts with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    smp_beat_t nb;
    if (rst) begin
      smp_if.valid     <= 1'b0;
      smp_if.sample    <= '0;
      smp_if.start_new <= 1'b0;
    end else if (!(smp_if.valid && !beat_in)) begin
      if (gap_left > 0) begin
        gap_left--;
        smp_if.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nb = pending_beats.pop_front();
        smp_if.sample    <= nb.value;
        smp_if.start_new <= nb.restart;
        smp_if.valid     <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: rotating stall pattern plus long hold-offs
  int rdy_cyc      = 0;
  int hold_left    = 0;
  int next_hold_at = 400;

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      rdy_cyc++;
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left    = 300;
        next_hold_at = next_hold_at + 1700;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case ((rdy_cyc / 97) % 4)
          0: begin
            res_if.ready <= 1'b1;
          end
          1: begin
            res_if.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            res_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            res_if.ready <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // monitor: predict on each sample beat, check each result beat
  always @(posedge clk) begin
    gap_res_t exp_r;
    if (rst) begin
      beat_in <= 1'b0;
      clear_seq();
    end else begin
      beat_in <= smp_if.valid && smp_if.ready;
      if (smp_if.valid && smp_if.ready) begin
        gap_expected.push_back(predict_gap(smp_if.sample, smp_if.start_new));
        samples_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (gap_expected.size() == 0) begin
          $error("unexpected result beat: best_gap %0d gap_valid %0b",
                 res_if.best_gap, res_if.gap_valid);
          errors++;
        end else begin
          exp_r = gap_expected.pop_front();
          if (res_if.best_gap !== exp_r.best_gap) begin
            $error("best_gap: expected %0d, actual %0d", exp_r.best_gap, res_if.best_gap);
            errors++;
          end
          if (res_if.gap_valid !== exp_r.gap_valid) begin
            $error("gap_valid: expected %0b, actual %0b", exp_r.gap_valid,
                   res_if.gap_valid);
            errors++;
          end
          if (exp_r.gap_valid) pair_results++;
          if (exp_r.best_gap > widest_gap) widest_gap = exp_r.best_gap;
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic queue_sample(logic [31:0] v, logic restart);
    smp_beat_t b;
    b.value   = v;
    b.restart = restart;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (samples_taken != beats_queued || gap_expected.size() != 0) @(negedge clk);
  endtask

  task automatic set_window(logic [CFG_W-1:0] k);
    wait_drained();
    repeat (8) @(negedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(REG_WINDOW_LEN * 4);
    pwdata  <= APB_DW'(k);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    win_cfg = k;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_run++;
  endtask

  // runs of random styles so that sums swing wide; rare mid-sequence restarts
  task automatic run_phase(int n, bit fresh);
    int          keff;
    int          style;
    int          run_left;
    logic [31:0] v;
    logic        restart;
    keff = (win_cfg == 0) ? 1 : ((win_cfg > MAXW) ? MAXW : int'(win_cfg));
    run_left = 0;
    style = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        style    = $urandom_range(0, 4);
        run_left = $urandom_range(1, 3 * keff + 4);
      end
      run_left--;
      case (style)
        0: begin
          v = $urandom;
        end
        1: begin
          v = 32'($signed($urandom_range(0, 127)) - 64);
        end
        2: begin
          v = 32'h7FFF_FFFF;
        end
        3: begin
          v = 32'h8000_0000;
        end
        default: begin
          v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                   : 32'h8000_0000 + $urandom_range(0, 255);
        end
      endcase
      restart = (i == 0) ? fresh : ($urandom_range(0, 199) == 0);
      queue_sample(v, restart);
    end
  endtask

  logic [31:0] dir_vals [15] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
  };
  int unsigned small_lens [9] = '{2, 3, 1, 5, 16, 0, 64, 7, 0};

  initial begin
    int keff;
    int n;
    win_cfg          = 1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes at the reset window of one, restart in the middle
    for (int i = 0; i < 15; i++) queue_sample(dir_vals[i], i == 9);

    // window length zero acts as one
    set_window(11'd0);
    queue_sample(32'h7FFF_FFFF, 1'b1);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h1234_5678, 1'b0);
    queue_sample(32'hFEDC_BA98, 1'b0);

    small_lens[8] = $urandom_range(8, 40);
    foreach (small_lens[i]) begin
      set_window(CFG_W'(small_lens[i]));
      keff = (small_lens[i] == 0) ? 1 : small_lens[i];
      n = 2 * keff + $urandom_range(40, 80);
      run_phase(n, 1'b1);
    end

    // widest window: full-scale positive run, then full-scale negative
    set_window(11'd1024);
    for (int i = 0; i < 200; i++) queue_sample(32'h7FFF_FFFF, i == 0);
    for (int i = 0; i < 40; i++) queue_sample(32'h8000_0000, 1'b0);

    // length above the maximum saturates
    set_window(11'd2047);
    run_phase(200, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (gap_expected.size() != 0) begin
      $error("%0d expected results never arrived", gap_expected.size());
    end
    $display("Run covered %0d samples and %0d results over %0d window settings;",
             samples_taken, results_seen, settings_run + 1);
    $display("%0d results carried a pair, widest gap %0d.", pair_results, widest_gap);
    if (errors == 0 && gap_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
